// ===== sv/assert_macros.svh =====
// Assertion helpers used by the top-level sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/i2cmts_pkg.sv =====
package i2cmts_pkg;

	// Item kinds carried on the input tuser.
	typedef enum logic [2:0] {
		KIND_LOAD  = 3'd0,
		KIND_START = 3'd1,
		KIND_EVENT = 3'd2,
		KIND_READ  = 3'd3,
		KIND_ERRH  = 3'd4
	} kind_t;

	// Bus status codes reported by the byte-level controller.
	localparam logic [3:0] ST_START      = 4'd0;
	localparam logic [3:0] ST_REP_START  = 4'd1;
	localparam logic [3:0] ST_WADR_ACK   = 4'd2;
	localparam logic [3:0] ST_WDATA_ACK  = 4'd3;
	localparam logic [3:0] ST_WADR_NACK  = 4'd4;
	localparam logic [3:0] ST_WDATA_NACK = 4'd5;
	localparam logic [3:0] ST_RADR_ACK   = 4'd6;
	localparam logic [3:0] ST_RADR_NACK  = 4'd7;
	localparam logic [3:0] ST_RDATA_ACK  = 4'd8;
	localparam logic [3:0] ST_RDATA_NACK = 4'd9;
	localparam logic [3:0] ST_ARB_LOST   = 4'd10;

	// Input tdata layout, last member in the lowest bits.
	typedef struct packed {
		logic [3:0] pad;
		logic [3:0] status_code;
		logic [7:0] data_byte;
		logic [3:0] buffer_index;
		logic [3:0] transfer_length;
		logic       read_not_write;
		logic [6:0] device_address;
	} in_data_t;

	// Output tdata layout, last member in the lowest bits.
	typedef struct packed {
		logic [2:0] pad;
		logic [7:0] read_byte;
		logic       read_valid;
		logic [3:0] error_code;
		logic       error_valid;
		logic       transfer_ok;
		logic [7:0] tx_byte;
		logic       tx_valid;
		logic       busy_res;
		logic       ack_next;
		logic       issue_stop;
		logic       issue_start;
		logic       accepted;
	} out_data_t;

	// Decision of the sequencer for one item, before the buffer data is merged.
	typedef struct packed {
		logic       accepted;
		logic       issue_start;
		logic       issue_stop;
		logic       ack_next;
		logic       busy_res;
		logic       tx_valid;
		logic       transfer_ok;
		logic       error_valid;
		logic [3:0] error_code;
		logic       read_valid;
	} ctrl_res_t;

endpackage

// ===== sv/i2cmts_ram.sv =====
module i2cmts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 17,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// One write port and one registered read port; read data holds without re.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/i2cmts_ctrl.sv =====
module i2cmts_ctrl #(
	parameter int BUFFER_DEPTH = 16,
	localparam int AW = $clog2(BUFFER_DEPTH + 1),
	localparam int PW = $clog2(BUFFER_DEPTH + 2)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  take,
	input  i2cmts_pkg::kind_t     kind,
	input  i2cmts_pkg::in_data_t  fields,
	output i2cmts_pkg::ctrl_res_t res,
	output logic                  ram_we,
	output logic [AW-1:0]         ram_waddr,
	output logic [7:0]            ram_wdata,
	output logic [AW-1:0]         ram_raddr
);

	localparam logic [PW-1:0] PTR_LAST = PW'(BUFFER_DEPTH);

	logic [PW-1:0] ptr_q, ptr_d;
	logic [PW-1:0] total_q, total_d;
	logic          busy_q, busy_d;
	logic          ok_q, ok_d;
	logic          err_q, err_d;
	logic [3:0]    ecode_q, ecode_d;

	// Per-item decision: next state, commands and buffer accesses.
	always_comb begin
		logic          idx_ok;
		logic          ptr_ok;
		logic [PW-1:0] ptr_eff;
		logic [PW-1:0] ptr_adv;
		logic [AW-1:0] idx_addr;

		idx_ok   = int'(fields.buffer_index) < BUFFER_DEPTH;
		ptr_ok   = ptr_q <= PTR_LAST;
		idx_addr = AW'(fields.buffer_index) + AW'(1);
		ptr_eff  = ptr_q;
		ptr_adv  = ptr_q;

		ptr_d   = ptr_q;
		total_d = total_q;
		busy_d  = busy_q;
		ok_d    = ok_q;
		err_d   = err_q;
		ecode_d = ecode_q;

		res           = '0;
		ram_we        = 1'b0;
		ram_waddr     = idx_addr;
		ram_wdata     = fields.data_byte;
		ram_raddr     = idx_addr;

		case (kind)
			i2cmts_pkg::KIND_LOAD: begin
				if (idx_ok) begin
					ram_we       = 1'b1;
					res.accepted = 1'b1;
				end
			end
			i2cmts_pkg::KIND_START: begin
				if (!busy_q) begin
					// Address byte goes into entry zero, ahead of the data.
					ram_we    = 1'b1;
					ram_waddr = '0;
					ram_wdata = {fields.device_address, fields.read_not_write};
					if (int'(fields.transfer_length) > BUFFER_DEPTH) begin
						total_d = PW'(BUFFER_DEPTH + 1);
					end else begin
						total_d = PW'(fields.transfer_length) + PW'(1);
					end
					ok_d            = 1'b0;
					err_d           = 1'b0;
					ecode_d         = '0;
					busy_d          = 1'b1;
					res.issue_start = 1'b1;
					res.accepted    = 1'b1;
				end
			end
			i2cmts_pkg::KIND_EVENT: begin
				if (busy_q) begin
					res.accepted = 1'b1;
					case (fields.status_code) inside
						i2cmts_pkg::ST_START, i2cmts_pkg::ST_REP_START,
						i2cmts_pkg::ST_WADR_ACK, i2cmts_pkg::ST_WDATA_ACK: begin
							// A (repeated) START rewinds to the address byte.
							if (fields.status_code == i2cmts_pkg::ST_START ||
									fields.status_code == i2cmts_pkg::ST_REP_START) begin
								ptr_eff = '0;
							end
							ram_raddr = AW'(ptr_eff);
							if (ptr_eff < total_q && ptr_eff <= PTR_LAST) begin
								res.tx_valid = 1'b1;
								ptr_d        = ptr_eff + PW'(1);
							end else begin
								ptr_d          = ptr_eff;
								ok_d           = 1'b1;
								res.issue_stop = 1'b1;
								busy_d         = 1'b0;
							end
						end
						i2cmts_pkg::ST_RDATA_ACK, i2cmts_pkg::ST_RADR_ACK: begin
							// Received bytes are stored and the pointer saturates past the end.
							if (fields.status_code == i2cmts_pkg::ST_RDATA_ACK && ptr_ok) begin
								ram_we    = 1'b1;
								ram_waddr = AW'(ptr_q);
								ptr_adv   = ptr_q + PW'(1);
							end
							ptr_d        = ptr_adv;
							res.ack_next = ({1'b0, ptr_adv} + (PW+1)'(1)) < {1'b0, total_q};
						end
						i2cmts_pkg::ST_RDATA_NACK: begin
							if (ptr_ok) begin
								ram_we    = 1'b1;
								ram_waddr = AW'(ptr_q);
							end
							ok_d           = 1'b1;
							res.issue_stop = 1'b1;
							busy_d         = 1'b0;
						end
						i2cmts_pkg::ST_ARB_LOST: begin
							res.issue_start = 1'b1;
						end
						default: begin
							ecode_d = fields.status_code;
							err_d   = 1'b1;
							busy_d  = 1'b0;
						end
					endcase
				end
			end
			i2cmts_pkg::KIND_READ: begin
				if (idx_ok) begin
					res.accepted   = 1'b1;
					res.read_valid = ok_q && !busy_q;
				end
			end
			i2cmts_pkg::KIND_ERRH: begin
				// An address NACK restarts the transfer when idle; other codes need no action.
				if (fields.status_code inside {i2cmts_pkg::ST_WADR_NACK,
						i2cmts_pkg::ST_RADR_NACK}) begin
					if (!busy_q) begin
						ok_d            = 1'b0;
						err_d           = 1'b0;
						ecode_d         = '0;
						busy_d          = 1'b1;
						res.issue_start = 1'b1;
						res.accepted    = 1'b1;
					end
				end else begin
					res.accepted = 1'b1;
				end
			end
			default: begin
			end
		endcase

		res.busy_res    = busy_d;
		res.transfer_ok = ok_d;
		res.error_valid = err_d;
		res.error_code  = ecode_d;
		ram_we          = ram_we && take;
	end

	// Transfer state, updated once per accepted item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q   <= '0;
			total_q <= '0;
			busy_q  <= 1'b0;
			ok_q    <= 1'b0;
			err_q   <= 1'b0;
			ecode_q <= '0;
		end else if (take) begin
			ptr_q   <= ptr_d;
			total_q <= total_d;
			busy_q  <= busy_d;
			ok_q    <= ok_d;
			err_q   <= err_d;
			ecode_q <= ecode_d;
		end
	end

endmodule

// ===== sv/i2c_master_transfer_sequencer.sv =====
// I2C master transfer sequencer. Each input transaction (load, start, bus
// event, read or error handle, selected by s_axis_tuser) produces exactly one
// result transaction carrying the commands for the byte-level controller and
// the status after the item. The block takes one transaction per clock; a
// result passes through stage one, where the registered read of the byte
// buffer (BUFFER_DEPTH+1 entries, entry zero holds the address byte) is done,
// and then the output register. Backpressure on the result side stalls the
// input only once both internal stages are full. Buffer entries that were
// never loaded or received read back as unknown data.
module i2c_master_transfer_sequencer #(
	parameter int BUFFER_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// device_address[6:0], read_not_write[7], transfer_length[11:8],
	// buffer_index[15:12], data_byte[23:16], status_code[27:24], zero[31:28]
	input  logic [31:0] s_axis_tdata,
	// kind[2:0]
	input  logic [2:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// accepted[0], issue_start[1], issue_stop[2], ack_next[3], busy_res[4],
	// tx_valid[5], tx_byte[13:6], transfer_ok[14], error_valid[15],
	// error_code[19:16], read_valid[20], read_byte[28:21], zero[31:29]
	output logic [31:0] m_axis_tdata
);

	localparam int AW = $clog2(BUFFER_DEPTH + 1);

	logic                   take;
	logic                   adv_s1;
	i2cmts_pkg::ctrl_res_t  res;
	i2cmts_pkg::ctrl_res_t  res_s1;
	logic                   valid_s1;
	logic                   valid_s2;
	i2cmts_pkg::out_data_t  data_s2;
	logic                   ram_we;
	logic [AW-1:0]          ram_waddr;
	logic [7:0]             ram_wdata;
	logic [AW-1:0]          ram_raddr;
	logic [7:0]             ram_rdata;

	// Stage one moves on whenever the output register is free or being emptied.
	assign adv_s1        = !valid_s2 || m_axis_tready;
	assign s_axis_tready = !valid_s1 || adv_s1;
	assign take          = s_axis_tvalid && s_axis_tready;

	i2cmts_ctrl #(
		.BUFFER_DEPTH(BUFFER_DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.kind      (i2cmts_pkg::kind_t'(s_axis_tuser)),
		.fields    (i2cmts_pkg::in_data_t'(s_axis_tdata)),
		.res       (res),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr)
	);

	i2cmts_ram #(
		.WIDTH(8),
		.DEPTH(BUFFER_DEPTH + 1)
	) u_buf (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (take),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Stage one: decision held while the buffer read completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_s1 <= res;
		end
	end

	// Stage two: output register with the buffer byte merged in.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && valid_s1) begin
			data_s2.pad         <= '0;
			data_s2.accepted    <= res_s1.accepted;
			data_s2.issue_start <= res_s1.issue_start;
			data_s2.issue_stop  <= res_s1.issue_stop;
			data_s2.ack_next    <= res_s1.ack_next;
			data_s2.busy_res    <= res_s1.busy_res;
			data_s2.tx_valid    <= res_s1.tx_valid;
			data_s2.tx_byte     <= res_s1.tx_valid ? ram_rdata : 8'h00;
			data_s2.transfer_ok <= res_s1.transfer_ok;
			data_s2.error_valid <= res_s1.error_valid;
			data_s2.error_code  <= res_s1.error_code;
			data_s2.read_valid  <= res_s1.read_valid;
			data_s2.read_byte   <= res_s1.read_valid ? ram_rdata : 8'h00;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = data_s2;

`include "assert_macros.svh"

	// The input side only stalls when both stages are full.
	`ASSERT_SAME(a_stall_cause, clk, arst_n, !s_axis_tready, valid_s1 && valid_s2, "input stalled without full pipeline")
	// A stalled first stage keeps its transaction.
	`ASSERT_NEXT(a_s1_hold, clk, arst_n, valid_s1 && !adv_s1, valid_s1 && $stable(res_s1), "stage one lost its transaction")
	// A transmit byte and a read byte never come with the same result.
	`ASSERT_SAME(a_one_byte, clk, arst_n, valid_s2, !(data_s2.tx_valid && data_s2.read_valid), "tx and read byte together")
	// STOP always ends the transfer, and success and error are exclusive.
	`ASSERT_SAME(a_stop_idle, clk, arst_n, valid_s2 && data_s2.issue_stop, !data_s2.busy_res && !data_s2.error_valid, "STOP while busy or in error")

endmodule

// ===== verif/testbench.sv =====
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int BUFFER_DEPTH = 16;
	localparam int TOTAL_ITEMS = 1050;
	localparam int LONG_HOLD_CYCLES = 120;
	localparam int MAX_PRINTED = 40;

	// Codes that the package leaves unnamed.
	localparam logic [2:0] KIND_UNUSED = 3'd7;
	localparam logic [3:0] ST_BUS_ERROR = 4'd11;
	localparam logic [3:0] ST_OTHER = 4'd12;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [31:0] s_axis_tdata = '0;
	logic [2:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;

	// Shadow copy of the sequencer state, advanced once per accepted transaction.
	logic [7:0] shadow_buf [0:BUFFER_DEPTH];
	int shadow_ptr = 0;
	int shadow_total = 0;
	bit shadow_busy = 1'b0;
	bit shadow_ok = 1'b0;
	bit shadow_err = 1'b0;
	logic [3:0] shadow_err_code = '0;

	i2cmts_pkg::out_data_t pending_results [$];
	int sent_items = 0;
	int fail_count = 0;
	bit src_idle = 1'b1;
	bit sink_idle = 1'b1;
	bit hold_request = 1'b0;

	i2c_master_transfer_sequencer #(
		.BUFFER_DEPTH(BUFFER_DEPTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always #5 clk = ~clk;

	task automatic report_mismatch(input string msg);
		fail_count++;
		if (fail_count <= MAX_PRINTED) begin
			$display("MISMATCH at %0t ns: %s", $time, msg);
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
		end
	endtask

	// Either put the next buffered byte on the bus or close the transfer with STOP.
	function automatic void next_tx_or_stop(inout i2cmts_pkg::out_data_t r);
		if (shadow_ptr < shadow_total && shadow_ptr <= BUFFER_DEPTH) begin
			r.tx_valid = 1'b1;
			r.tx_byte = shadow_buf[shadow_ptr];
			shadow_ptr++;
		end else begin
			shadow_ok = 1'b1;
			r.issue_stop = 1'b1;
			shadow_busy = 1'b0;
		end
	endfunction

	// Works out the result of one accepted transaction and updates the shadow state.
	function automatic i2cmts_pkg::out_data_t predict_result(input logic [2:0] kind,
			input i2cmts_pkg::in_data_t d);
		i2cmts_pkg::out_data_t r;
		int len;
		r = '0;
		case (kind)
			i2cmts_pkg::KIND_LOAD: begin
				if (int'(d.buffer_index) < BUFFER_DEPTH) begin
					shadow_buf[int'(d.buffer_index) + 1] = d.data_byte;
					r.accepted = 1'b1;
				end
			end
			i2cmts_pkg::KIND_START: begin
				if (!shadow_busy) begin
					len = int'(d.transfer_length);
					if (len > BUFFER_DEPTH) begin
						len = BUFFER_DEPTH;
					end
					shadow_buf[0] = {d.device_address, d.read_not_write};
					shadow_total = len + 1;
					shadow_ok = 1'b0;
					shadow_err = 1'b0;
					shadow_err_code = '0;
					shadow_busy = 1'b1;
					r.issue_start = 1'b1;
					r.accepted = 1'b1;
				end
			end
			i2cmts_pkg::KIND_EVENT: begin
				if (shadow_busy) begin
					r.accepted = 1'b1;
					case (d.status_code)
						i2cmts_pkg::ST_START, i2cmts_pkg::ST_REP_START: begin
							shadow_ptr = 0;
							next_tx_or_stop(r);
						end
						i2cmts_pkg::ST_WADR_ACK, i2cmts_pkg::ST_WDATA_ACK: begin
							next_tx_or_stop(r);
						end
						i2cmts_pkg::ST_RDATA_ACK: begin
							if (shadow_ptr <= BUFFER_DEPTH) begin
								shadow_buf[shadow_ptr] = d.data_byte;
								shadow_ptr++;
							end
							r.ack_next = (shadow_ptr + 1 < shadow_total);
						end
						i2cmts_pkg::ST_RADR_ACK: begin
							r.ack_next = (shadow_ptr + 1 < shadow_total);
						end
						i2cmts_pkg::ST_RDATA_NACK: begin
							if (shadow_ptr <= BUFFER_DEPTH) begin
								shadow_buf[shadow_ptr] = d.data_byte;
							end
							shadow_ok = 1'b1;
							r.issue_stop = 1'b1;
							shadow_busy = 1'b0;
						end
						i2cmts_pkg::ST_ARB_LOST: begin
							r.issue_start = 1'b1;
						end
						default: begin
							shadow_err_code = d.status_code;
							shadow_err = 1'b1;
							shadow_busy = 1'b0;
						end
					endcase
				end
			end
			i2cmts_pkg::KIND_READ: begin
				if (int'(d.buffer_index) < BUFFER_DEPTH) begin
					r.accepted = 1'b1;
					if (shadow_ok && !shadow_busy) begin
						r.read_valid = 1'b1;
						r.read_byte = shadow_buf[int'(d.buffer_index) + 1];
					end
				end
			end
			i2cmts_pkg::KIND_ERRH: begin
				if (d.status_code == i2cmts_pkg::ST_WADR_NACK ||
						d.status_code == i2cmts_pkg::ST_RADR_NACK) begin
					if (!shadow_busy) begin
						shadow_ok = 1'b0;
						shadow_err = 1'b0;
						shadow_err_code = '0;
						shadow_busy = 1'b1;
						r.issue_start = 1'b1;
						r.accepted = 1'b1;
					end
				end else begin
					r.accepted = 1'b1;
				end
			end
			default: begin
			end
		endcase
		r.busy_res = shadow_busy;
		r.transfer_ok = shadow_ok;
		r.error_valid = shadow_err;
		r.error_code = shadow_err_code;
		return r;
	endfunction

	function automatic i2cmts_pkg::in_data_t random_fields();
		i2cmts_pkg::in_data_t d;
		d = '0;
		d.device_address = 7'($urandom_range(0, 127));
		d.read_not_write = 1'($urandom_range(0, 1));
		d.transfer_length = 4'($urandom_range(0, 15));
		d.buffer_index = 4'($urandom_range(0, 15));
		d.data_byte = 8'($urandom_range(0, 255));
		d.status_code = 4'($urandom_range(0, 15));
		return d;
	endfunction

	function automatic logic [3:0] random_error_code();
		case ($urandom_range(0, 4))
			0: return i2cmts_pkg::ST_WADR_NACK;
			1: return i2cmts_pkg::ST_WDATA_NACK;
			2: return i2cmts_pkg::ST_RADR_NACK;
			3: return ST_BUS_ERROR;
			default: return 4'(ST_OTHER + $urandom_range(0, 3));
		endcase
	endfunction

	// Offers one input transaction, after a random gap while src_idle is set, and records its expected result.
	task automatic send_item(input logic [2:0] kind, input i2cmts_pkg::in_data_t d);
		int unsigned gap;
		i2cmts_pkg::out_data_t want;
		gap = src_idle ? $urandom_range(0, 15) : 0;
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= d;
		s_axis_tuser <= kind;
		do @(posedge clk); while (!s_axis_tready);
		want = predict_result(kind, d);
		pending_results.push_back(want);
		sent_items++;
	endtask

	task automatic send_load(input int idx, input logic [7:0] value);
		i2cmts_pkg::in_data_t d;
		d = random_fields();
		d.buffer_index = 4'(idx);
		d.data_byte = value;
		send_item(i2cmts_pkg::KIND_LOAD, d);
	endtask

	task automatic send_start(input logic [6:0] addr, input logic rnw, input int len);
		i2cmts_pkg::in_data_t d;
		d = random_fields();
		d.device_address = addr;
		d.read_not_write = rnw;
		d.transfer_length = 4'(len);
		send_item(i2cmts_pkg::KIND_START, d);
	endtask

	task automatic send_event(input logic [3:0] code);
		i2cmts_pkg::in_data_t d;
		d = random_fields();
		d.status_code = code;
		send_item(i2cmts_pkg::KIND_EVENT, d);
	endtask

	task automatic send_read(input int idx);
		i2cmts_pkg::in_data_t d;
		d = random_fields();
		d.buffer_index = 4'(idx);
		send_item(i2cmts_pkg::KIND_READ, d);
	endtask

	task automatic send_errh(input logic [3:0] code);
		i2cmts_pkg::in_data_t d;
		d = random_fields();
		d.status_code = code;
		send_item(i2cmts_pkg::KIND_ERRH, d);
	endtask

	// One transfer as the bus would report it, with occasional lost arbitration
	// and errors, always run to its end so the next start is taken.
	task automatic run_transfer(input bit rnw);
		int len;
		int steps;
		len = ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 15)) :
			int'($urandom_range(0, 3));
		send_start(7'($urandom_range(0, 127)), rnw, len);
		send_event(($urandom_range(0, 3) == 0) ? i2cmts_pkg::ST_REP_START :
			i2cmts_pkg::ST_START);
		if (rnw) begin
			send_event(i2cmts_pkg::ST_RADR_ACK);
			// Now and then the bus keeps acknowledging past the buffer end.
			steps = ($urandom_range(0, 9) == 0) ? BUFFER_DEPTH + 4 : len;
		end else begin
			steps = len + 1;
		end
		for (int i = 0; i < steps && shadow_busy; i++) begin
			case ($urandom_range(0, 24))
				0: begin
					send_event(i2cmts_pkg::ST_ARB_LOST);
					send_event(i2cmts_pkg::ST_START);
					if (rnw) begin
						send_event(i2cmts_pkg::ST_RADR_ACK);
					end
				end
				1: begin
					send_event(random_error_code());
					send_errh(($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) :
						(rnw ? i2cmts_pkg::ST_RADR_NACK : i2cmts_pkg::ST_WADR_NACK));
					if (shadow_busy) begin
						send_event(i2cmts_pkg::ST_START);
					end
				end
				default: begin
					if (rnw) begin
						send_event(i2cmts_pkg::ST_RDATA_ACK);
					end else begin
						send_event((i == 0) ? i2cmts_pkg::ST_WADR_ACK :
							i2cmts_pkg::ST_WDATA_ACK);
					end
				end
			endcase
		end
		while (shadow_busy) begin
			send_event(rnw ? i2cmts_pkg::ST_RDATA_NACK : i2cmts_pkg::ST_WDATA_ACK);
		end
	endtask

	// Every data entry of the buffer is written once before anything can read or send it.
	task automatic test_buffer_fill();
		for (int i = 0; i < BUFFER_DEPTH; i++) begin
			if (i == 0) begin
				send_load(i, 8'h00);
			end else if (i == BUFFER_DEPTH - 1) begin
				send_load(i, 8'hFF);
			end else begin
				send_load(i, 8'($urandom_range(0, 255)));
			end
		end
	endtask

	// Items that have nothing to act on while the sequencer is idle.
	task automatic test_idle_items();
		send_read(0);
		send_event(i2cmts_pkg::ST_WADR_ACK);
		send_errh(i2cmts_pkg::ST_WDATA_NACK);
		send_item(KIND_UNUSED, random_fields());
	endtask

	task automatic test_write_transfer();
		send_start(7'h7F, 1'b0, 1);
		send_start(7'h00, 1'b1, 3);
		send_event(i2cmts_pkg::ST_START);
		send_event(i2cmts_pkg::ST_ARB_LOST);
		send_event(i2cmts_pkg::ST_REP_START);
		send_event(i2cmts_pkg::ST_WADR_ACK);
		send_event(i2cmts_pkg::ST_WDATA_ACK);
		send_read(BUFFER_DEPTH - 1);
	endtask

	task automatic test_error_recovery();
		send_start(7'h00, 1'b1, 15);
		send_event(i2cmts_pkg::ST_WADR_NACK);
		send_errh(i2cmts_pkg::ST_WADR_NACK);
		send_errh(i2cmts_pkg::ST_RADR_NACK);
		send_event(ST_BUS_ERROR);
		send_errh(i2cmts_pkg::ST_RADR_NACK);
	endtask

	task automatic test_read_transfer();
		send_event(i2cmts_pkg::ST_START);
		send_event(i2cmts_pkg::ST_RADR_ACK);
		send_event(i2cmts_pkg::ST_RDATA_ACK);
		send_event(i2cmts_pkg::ST_RDATA_NACK);
		send_read(0);
		send_read(1);
	endtask

	// The result side stops for a long stretch while input keeps coming.
	task automatic test_result_backpressure();
		src_idle = 1'b0;
		hold_request = 1'b1;
		run_transfer(1'b0);
		repeat (8) send_read(int'($urandom_range(0, BUFFER_DEPTH - 1)));
		src_idle = 1'b1;
	endtask

	task automatic test_random_traffic();
		while (sent_items < TOTAL_ITEMS) begin
			if ($urandom_range(0, 15) == 0) begin
				src_idle = ($urandom_range(0, 2) != 0);
				sink_idle = ($urandom_range(0, 2) != 0);
			end
			case ($urandom_range(0, 9))
				0, 1: begin
					repeat ($urandom_range(1, 4)) begin
						send_load(int'($urandom_range(0, BUFFER_DEPTH - 1)),
							8'($urandom_range(0, 255)));
					end
				end
				2, 3, 4: run_transfer(1'b0);
				5, 6, 7: run_transfer(1'b1);
				8: begin
					repeat ($urandom_range(1, 3)) begin
						send_read(int'($urandom_range(0, BUFFER_DEPTH - 1)));
					end
				end
				default: begin
					repeat ($urandom_range(1, 3)) begin
						send_item(3'($urandom_range(0, 7)), random_fields());
					end
				end
			endcase
		end
	endtask

	// Result side: random stalls, plus one long hold when a test asks for it.
	initial begin : result_sink
		int unsigned gap;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
			end
			gap = sink_idle ? $urandom_range(0, 15) : 0;
			if (gap != 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
		end
	end

	// Compare each result transaction with the oldest expected one.
	always @(posedge clk) begin : result_check
		i2cmts_pkg::out_data_t got;
		i2cmts_pkg::out_data_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata;
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("result %0h arrived with none expected", got));
			end else begin
				want = pending_results.pop_front();
				check_field("accepted", 32'(got.accepted), 32'(want.accepted));
				check_field("issue_start", 32'(got.issue_start), 32'(want.issue_start));
				check_field("issue_stop", 32'(got.issue_stop), 32'(want.issue_stop));
				check_field("ack_next", 32'(got.ack_next), 32'(want.ack_next));
				check_field("busy_res", 32'(got.busy_res), 32'(want.busy_res));
				check_field("tx_valid", 32'(got.tx_valid), 32'(want.tx_valid));
				check_field("tx_byte", 32'(got.tx_byte), 32'(want.tx_byte));
				check_field("transfer_ok", 32'(got.transfer_ok), 32'(want.transfer_ok));
				check_field("error_valid", 32'(got.error_valid), 32'(want.error_valid));
				check_field("error_code", 32'(got.error_code), 32'(want.error_code));
				check_field("read_valid", 32'(got.read_valid), 32'(want.read_valid));
				check_field("read_byte", 32'(got.read_byte), 32'(want.read_byte));
			end
		end
	end

	initial begin
		#5ms;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_buffer_fill();
		test_idle_items();
		test_write_transfer();
		test_error_recovery();
		test_read_transfer();
		test_result_backpressure();
		test_random_traffic();

		// Let every outstanding result drain, then a few more cycles.
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (fail_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+sv
sv/i2cmts_pkg.sv
sv/i2cmts_ram.sv
sv/i2cmts_ctrl.sv
sv/i2c_master_transfer_sequencer.sv
verif/testbench.sv
